// ===== hdl/pss_pkg.sv =====
// Shared types, codes and constants of the packer signature scanner.
package pss_pkg;

    localparam int MAX_VERSION_CHARS  = 16;
    localparam int MARKER_SEARCH_SPAN = 24;

    localparam int MAGIC_LEN  = 4;
    localparam int HDR_LEN    = 8;
    localparam int BANNER_LEN = 21;
    localparam int MARK_LEN   = 10;
    localparam int LEVEL_MAX  = 10;
    localparam int VER_LIMIT  = 64;

    // Byte strings, first character in the most significant byte.
    localparam logic [8*MAGIC_LEN-1:0]  HDR_MAGIC  = 32'h55_50_58_21;
    localparam logic [8*MAGIC_LEN-1:0]  REL_LEAD   = 32'h55_50_58_20;
    localparam logic [8*BANNER_LEN-1:0] BANNER_TXT =
        168'h55_50_58_20_65_78_65_63_75_74_61_62_6C_65_20_70_61_63_6B_65_72;
    localparam logic [8*MARK_LEN-1:0]   COPY_MARK  = 80'h20_43_6F_70_79_72_69_67_68_74;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    typedef enum logic [1:0] {
        ACT_PREFIX = 2'd0,
        ACT_SUFFIX = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_IGNORE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ASSESS_NONE     = 2'd0,
        ASSESS_STANDARD = 2'd1,
        ASSESS_MODIFIED = 2'd2
    } assess_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALIGN,
        S_FLUSH,
        S_SCAN,
        S_RUN,
        S_SEARCH,
        S_PUSH,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic push_in;
        logic push_pend;
        logic align_load;
        logic align_step;
        logic scan;
        logic rel_load;
        logic run_step;
        logic search_step;
        logic rel_commit;
        logic drop;
        logic drop_shift;
        logic emit_step;
        logic clear_all;
    } pss_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic count_pre_full;
        logic pad_zero;
        logic region_match;
        logic rel_cand;
        logic run_fail;
        logic run_break;
        logic run_ok;
        logic srch_hit;
        logic srch_end;
        logic last;
    } pss_stat_t;

endpackage

// ===== hdl/pss_if.sv =====
// Input and result channel interfaces of the packer signature scanner.
interface pss_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       container_is_pe;
    logic       canonical_layout;
    logic       packed_layout;

    modport source (output valid, action, data_byte, container_is_pe, canonical_layout,
                    packed_layout, input ready);
    modport sink (input valid, action, data_byte, container_is_pe, canonical_layout,
                  packed_layout, output ready);
endinterface

interface pss_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] assessment;
    logic       header_found;
    logic [5:0] header_version;
    logic       release_found;
    logic [7:0] release_char;
    logic       last_result;

    modport source (output valid, assessment, header_found, header_version, release_found,
                    release_char, last_result, input ready);
    modport sink (input valid, assessment, header_found, header_version, release_found,
                  release_char, last_result, output ready);
endinterface

// ===== hdl/pss_ctrl.sv =====
// Controller state machine of the packer signature scanner.
module pss_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          action,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  pss_pkg::pss_stat_t  st,
    output pss_pkg::pss_cmd_t   cmd
);

    pss_pkg::state_t state_reg, state_next;
    logic            fin_reg, fin_next;
    logic            flush_reg, flush_next;
    pss_pkg::state_t ret_state;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pss_pkg::S_IDLE;
            fin_reg   <= 1'b0;
            flush_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            flush_reg <= flush_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        flush_next = flush_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        ret_state  = flush_reg ? pss_pkg::S_FLUSH : pss_pkg::S_IDLE;
        cmd.drop_shift = flush_reg;

        case (state_reg)
            pss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    case (pss_pkg::action_t'(action))
                        pss_pkg::ACT_PREFIX, pss_pkg::ACT_SUFFIX:
                        begin
                            if (st.region_match || st.count_zero)
                            begin
                                cmd.push_in = 1'b1;
                                if (st.count_pre_full)
                                begin
                                    flush_next = 1'b0;
                                    state_next = pss_pkg::S_SCAN;
                                end
                            end
                            else
                            begin
                                // A new region: the old tail is scanned out first.
                                fin_next       = 1'b0;
                                flush_next     = 1'b1;
                                cmd.align_load = 1'b1;
                                state_next     = pss_pkg::S_ALIGN;
                            end
                        end
                        pss_pkg::ACT_FINISH:
                        begin
                            fin_next       = 1'b1;
                            flush_next     = 1'b1;
                            cmd.align_load = 1'b1;
                            state_next     = st.count_zero ? pss_pkg::S_FLUSH
                                                           : pss_pkg::S_ALIGN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            pss_pkg::S_ALIGN:
            begin
                if (st.pad_zero)
                begin
                    state_next = pss_pkg::S_FLUSH;
                end
                else
                begin
                    cmd.align_step = 1'b1;
                end
            end
            pss_pkg::S_FLUSH:
            begin
                if (st.count_zero)
                begin
                    flush_next = 1'b0;
                    state_next = fin_reg ? pss_pkg::S_EMIT : pss_pkg::S_PUSH;
                end
                else
                begin
                    state_next = pss_pkg::S_SCAN;
                end
            end
            pss_pkg::S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (st.rel_cand)
                begin
                    cmd.rel_load = 1'b1;
                    state_next   = pss_pkg::S_RUN;
                end
                else
                begin
                    cmd.drop   = 1'b1;
                    state_next = ret_state;
                end
            end
            pss_pkg::S_RUN:
            begin
                if (st.run_fail || (st.run_break && !st.run_ok))
                begin
                    cmd.drop   = 1'b1;
                    state_next = ret_state;
                end
                else
                begin
                    cmd.run_step = 1'b1;
                    if (st.run_break)
                    begin
                        state_next = pss_pkg::S_SEARCH;
                    end
                end
            end
            pss_pkg::S_SEARCH:
            begin
                if (st.srch_hit)
                begin
                    cmd.rel_commit = 1'b1;
                    cmd.drop       = 1'b1;
                    state_next     = ret_state;
                end
                else if (st.srch_end)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ret_state;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            pss_pkg::S_PUSH:
            begin
                cmd.push_pend = 1'b1;
                state_next    = pss_pkg::S_IDLE;
            end
            pss_pkg::S_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (st.last)
                    begin
                        cmd.clear_all = 1'b1;
                        fin_next      = 1'b0;
                        state_next    = pss_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.emit_step = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = pss_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/pss_datapath.sv =====
// Datapath of the packer signature scanner: byte window, matchers and result fields.
module pss_datapath #(
    parameter int MAX_VERSION_CHARS  = pss_pkg::MAX_VERSION_CHARS,
    parameter int MARKER_SEARCH_SPAN = pss_pkg::MARKER_SEARCH_SPAN
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pss_pkg::pss_cmd_t  cmd,
    output pss_pkg::pss_stat_t st,
    input  logic [1:0]         action,
    input  logic [7:0]         data_byte,
    input  logic               container_is_pe,
    input  logic               canonical_layout,
    input  logic               packed_layout,
    output logic [1:0]         assessment,
    output logic               header_found,
    output logic [5:0]         header_version,
    output logic               release_found,
    output logic [7:0]         release_char,
    output logic               last_result
);

    localparam int WIN_LEN  = pss_pkg::MAGIC_LEN + MAX_VERSION_CHARS + MARKER_SEARCH_SPAN;
    localparam int SRCH_LEN = WIN_LEN - pss_pkg::MAGIC_LEN;
    localparam int CNT_W    = $clog2(WIN_LEN + 1);
    localparam int LEN_W    = $clog2(MAX_VERSION_CHARS + 1);
    localparam int OFF_W    = $clog2(MAX_VERSION_CHARS + 2);
    localparam int S_W      = $clog2(MARKER_SEARCH_SPAN + 1);
    localparam int IDX_W    = $clog2(MAX_VERSION_CHARS);
    localparam int ML       = pss_pkg::MAGIC_LEN;

    logic [7:0]       win_reg [WIN_LEN];
    logic [7:0]       win_next [WIN_LEN];
    logic [7:0]       sreg_reg [SRCH_LEN];
    logic [7:0]       sreg_next [SRCH_LEN];
    logic [7:0]       text_reg [MAX_VERSION_CHARS];
    logic [7:0]       text_next [MAX_VERSION_CHARS];
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             pend_act_reg, pend_act_next;
    logic             pe_reg, pe_next;
    logic             canon_reg, canon_next;
    logic             packed_reg, packed_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pad_reg, pad_next;
    logic             region_valid_reg, region_valid_next;
    logic             region_act_reg, region_act_next;
    logic             hdr_hit_reg, hdr_hit_next;
    logic [5:0]       hdr_val_reg, hdr_val_next;
    logic             ban_hit_reg, ban_hit_next;
    logic             rel_hit_reg, rel_hit_next;
    logic [LEN_W-1:0] rel_len_reg, rel_len_next;
    logic [OFF_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [1:0]       parts_reg, parts_next;
    logic             run_ne_reg, run_ne_next;
    logic [S_W-1:0]   srch_reg, srch_next;
    logic [LEN_W-1:0] k_reg, k_next;

    logic             magic_eq, lead_eq, banner_eq, mark_eq;
    logic             hdr_ok;
    logic             win_shift;
    logic [7:0]       win_fill;
    logic [7:0]       head;
    logic             have, dig, dot;
    logic [1:0]       parts_inc, parts_fin;
    logic [OFF_W-1:0] cur_inc;
    logic             over, adv;
    logic             run_fail, run_break, run_ok;
    logic [S_W:0]     srch_pos;
    logic             srch_cond;
    logic             det, std_ok, n_is_len;
    logic [LEN_W:0]   k_inc;

    // Fixed pattern compares at the window head.
    always_comb
    begin
        magic_eq  = 1'b1;
        lead_eq   = 1'b1;
        banner_eq = 1'b1;
        mark_eq   = 1'b1;
        for (int i = 0; i < ML; i++)
        begin
            if (win_reg[i] != pss_pkg::HDR_MAGIC[8*(ML-1-i) +: 8])
            begin
                magic_eq = 1'b0;
            end
            if (win_reg[i] != pss_pkg::REL_LEAD[8*(ML-1-i) +: 8])
            begin
                lead_eq = 1'b0;
            end
        end
        for (int i = 0; i < pss_pkg::BANNER_LEN; i++)
        begin
            if (win_reg[i] != pss_pkg::BANNER_TXT[8*(pss_pkg::BANNER_LEN-1-i) +: 8])
            begin
                banner_eq = 1'b0;
            end
        end
        for (int i = 0; i < pss_pkg::MARK_LEN; i++)
        begin
            if (sreg_reg[i] != pss_pkg::COPY_MARK[8*(pss_pkg::MARK_LEN-1-i) +: 8])
            begin
                mark_eq = 1'b0;
            end
        end
    end

    assign hdr_ok = !hdr_hit_reg && (count_reg >= CNT_W'(pss_pkg::HDR_LEN)) && magic_eq &&
                    (win_reg[4] != 8'd0) && (win_reg[4] < 8'(pss_pkg::VER_LIMIT)) &&
                    (win_reg[5] != 8'd0) && (win_reg[6] != 8'd0) &&
                    (win_reg[7] >= 8'd1) && (win_reg[7] <= 8'(pss_pkg::LEVEL_MAX));

    // One step of the dotted version parse, looking at the head of the scan line.
    always_comb
    begin
        head      = sreg_reg[0];
        have      = (rem_reg != '0);
        dig       = have && (head >= pss_pkg::CHAR_ZERO) && (head <= pss_pkg::CHAR_NINE);
        dot       = have && (head == pss_pkg::CHAR_DOT);
        parts_inc = parts_reg + 2'd1;
        cur_inc   = cur_reg + OFF_W'(1);
        over      = (cur_inc > OFF_W'(MAX_VERSION_CHARS));
        adv       = 1'b0;
        parts_fin = parts_reg;
        run_fail  = 1'b0;
        run_break = 1'b0;
        if (dig)
        begin
            adv      = 1'b1;
            run_fail = over;
        end
        else if (!run_ne_reg)
        begin
            run_break = 1'b1;
        end
        else
        begin
            parts_fin = parts_inc;
            if ((parts_inc == 2'd3) || !dot)
            begin
                run_break = 1'b1;
            end
            else
            begin
                adv      = 1'b1;
                run_fail = over;
            end
        end
        run_ok = (parts_fin >= 2'd2);
    end

    assign st.run_fail  = run_fail;
    assign st.run_break = run_break;
    assign st.run_ok    = run_ok;

    assign srch_pos    = {1'b0, srch_reg} + (S_W+1)'(pss_pkg::MARK_LEN);
    assign srch_cond   = (rem_reg >= CNT_W'(pss_pkg::MARK_LEN)) &&
                         (srch_pos <= (S_W+1)'(MARKER_SEARCH_SPAN));
    assign st.srch_hit = srch_cond && mark_eq;
    assign st.srch_end = !srch_cond;

    assign st.count_zero     = (count_reg == '0);
    assign st.count_pre_full = (count_reg == CNT_W'(WIN_LEN - 1));
    assign st.pad_zero       = (pad_reg == '0);
    assign st.region_match   = region_valid_reg && (region_act_reg == action[0]);
    assign st.rel_cand       = !rel_hit_reg && (count_reg > CNT_W'(ML)) && lead_eq;

    // Result fields of the finish run.
    always_comb
    begin
        if (pe_reg)
        begin
            det    = canon_reg || packed_reg || hdr_hit_reg;
            std_ok = canon_reg && hdr_hit_reg;
        end
        else
        begin
            det    = packed_reg || hdr_hit_reg || ban_hit_reg || rel_hit_reg;
            std_ok = packed_reg && (ban_hit_reg || rel_hit_reg || hdr_hit_reg);
        end
        if (!det)
        begin
            assessment = pss_pkg::ASSESS_NONE;
        end
        else if (std_ok)
        begin
            assessment = pss_pkg::ASSESS_STANDARD;
        end
        else
        begin
            assessment = pss_pkg::ASSESS_MODIFIED;
        end
        n_is_len       = det && rel_hit_reg && (rel_len_reg != '0);
        k_inc          = {1'b0, k_reg} + (LEN_W+1)'(1);
        last_result    = n_is_len ? (k_inc == {1'b0, rel_len_reg}) : 1'b1;
        header_found   = det && hdr_hit_reg;
        header_version = header_found ? hdr_val_reg : 6'd0;
        release_found  = det && rel_hit_reg;
        release_char   = (release_found && (k_reg < rel_len_reg)) ?
                         text_reg[k_reg[IDX_W-1:0]] : 8'd0;
    end

    assign st.last = last_result;

    always_comb
    begin
        win_next          = win_reg;
        sreg_next         = sreg_reg;
        text_next         = text_reg;
        pend_byte_next    = pend_byte_reg;
        pend_act_next     = pend_act_reg;
        pe_next           = pe_reg;
        canon_next        = canon_reg;
        packed_next       = packed_reg;
        count_next        = count_reg;
        pad_next          = pad_reg;
        region_valid_next = region_valid_reg;
        region_act_next   = region_act_reg;
        hdr_hit_next      = hdr_hit_reg;
        hdr_val_next      = hdr_val_reg;
        ban_hit_next      = ban_hit_reg;
        rel_hit_next      = rel_hit_reg;
        rel_len_next      = rel_len_reg;
        cur_next          = cur_reg;
        rem_next          = rem_reg;
        parts_next        = parts_reg;
        run_ne_next       = run_ne_reg;
        srch_next         = srch_reg;
        k_next            = k_reg;

        if (cmd.capture)
        begin
            pend_byte_next = data_byte;
            pend_act_next  = action[0];
            pe_next        = container_is_pe;
            canon_next     = canonical_layout;
            packed_next    = packed_layout;
        end

        // Bytes enter at the top of the window; the scan position is entry zero.
        win_shift = cmd.push_in || cmd.push_pend || cmd.align_step ||
                    (cmd.drop && cmd.drop_shift);
        win_fill  = cmd.push_in ? data_byte : (cmd.push_pend ? pend_byte_reg : 8'd0);
        if (win_shift)
        begin
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                win_next[i] = win_reg[i+1];
            end
            win_next[WIN_LEN-1] = win_fill;
        end

        if (cmd.push_in || cmd.push_pend)
        begin
            count_next        = count_reg + CNT_W'(1);
            region_valid_next = 1'b1;
            region_act_next   = cmd.push_in ? action[0] : pend_act_reg;
        end
        if (cmd.drop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.align_load)
        begin
            pad_next = CNT_W'(WIN_LEN) - count_reg;
        end
        if (cmd.align_step)
        begin
            pad_next = pad_reg - CNT_W'(1);
        end

        if (cmd.scan)
        begin
            if (hdr_ok)
            begin
                hdr_hit_next = 1'b1;
                hdr_val_next = win_reg[4][5:0];
            end
            if ((count_reg >= CNT_W'(pss_pkg::BANNER_LEN)) && banner_eq)
            begin
                ban_hit_next = 1'b1;
            end
        end

        if (cmd.rel_load)
        begin
            for (int i = 0; i < SRCH_LEN; i++)
            begin
                sreg_next[i] = win_reg[i+ML];
            end
            cur_next    = '0;
            rem_next    = count_reg - CNT_W'(ML);
            parts_next  = 2'd0;
            run_ne_next = 1'b0;
        end

        if (cmd.run_step || cmd.search_step)
        begin
            if (adv || cmd.search_step)
            begin
                for (int i = 0; i < SRCH_LEN - 1; i++)
                begin
                    sreg_next[i] = sreg_reg[i+1];
                end
                sreg_next[SRCH_LEN-1] = 8'd0;
                rem_next = rem_reg - CNT_W'(1);
            end
        end
        if (cmd.run_step)
        begin
            parts_next = parts_fin;
            if (adv)
            begin
                cur_next    = cur_inc;
                run_ne_next = dig;
            end
            if (run_break)
            begin
                srch_next = '0;
            end
        end
        if (cmd.search_step)
        begin
            srch_next = srch_reg + S_W'(1);
        end

        if (cmd.rel_commit)
        begin
            rel_hit_next = 1'b1;
            rel_len_next = cur_reg[LEN_W-1:0];
            for (int i = 0; i < MAX_VERSION_CHARS; i++)
            begin
                text_next[i] = win_reg[i+ML];
            end
        end

        if (cmd.emit_step)
        begin
            k_next = k_inc[LEN_W-1:0];
        end
        if (cmd.clear_all)
        begin
            count_next        = '0;
            region_valid_next = 1'b0;
            hdr_hit_next      = 1'b0;
            hdr_val_next      = 6'd0;
            ban_hit_next      = 1'b0;
            rel_hit_next      = 1'b0;
            rel_len_next      = '0;
            k_next            = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg        <= '0;
            pad_reg          <= '0;
            region_valid_reg <= 1'b0;
            region_act_reg   <= 1'b0;
            hdr_hit_reg      <= 1'b0;
            hdr_val_reg      <= 6'd0;
            ban_hit_reg      <= 1'b0;
            rel_hit_reg      <= 1'b0;
            rel_len_reg      <= '0;
            cur_reg          <= '0;
            rem_reg          <= '0;
            parts_reg        <= 2'd0;
            run_ne_reg       <= 1'b0;
            srch_reg         <= '0;
            k_reg            <= '0;
            pe_reg           <= 1'b0;
            canon_reg        <= 1'b0;
            packed_reg       <= 1'b0;
        end
        else
        begin
            count_reg        <= count_next;
            pad_reg          <= pad_next;
            region_valid_reg <= region_valid_next;
            region_act_reg   <= region_act_next;
            hdr_hit_reg      <= hdr_hit_next;
            hdr_val_reg      <= hdr_val_next;
            ban_hit_reg      <= ban_hit_next;
            rel_hit_reg      <= rel_hit_next;
            rel_len_reg      <= rel_len_next;
            cur_reg          <= cur_next;
            rem_reg          <= rem_next;
            parts_reg        <= parts_next;
            run_ne_reg       <= run_ne_next;
            srch_reg         <= srch_next;
            k_reg            <= k_next;
            pe_reg           <= pe_next;
            canon_reg        <= canon_next;
            packed_reg       <= packed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        sreg_reg      <= sreg_next;
        text_reg      <= text_next;
        pend_byte_reg <= pend_byte_next;
        pend_act_reg  <= pend_act_next;
    end

endmodule

// ===== hdl/packer_signature_scanner_top.sv =====
// Top level of the packer signature scanner.
// Usage: words arrive on the items channel: prefix bytes, then suffix bytes, then one
// finish word that carries the layout evidence. A finish word produces a run of
// 1 to MAX_VERSION_CHARS result words on the results channel, the last one marked by
// last_result; action 3 is taken and dropped.
// Input: bytes are taken while the window of
// 4 + MAX_VERSION_CHARS + MARKER_SEARCH_SPAN bytes fills; once it is full, the byte
// leaving the window head is checked in S_SCAN before the next byte is taken. When a
// release lead sits at the window head, the version parse and the marker search walk
// the window one byte a cycle. A region change or a finish word scans out the window
// tail first: an alignment pass pads the window, then each remaining byte is checked
// at the window head in turn, with the parses where a release lead sits there.
// Results: the first result word is shown once the flush has emptied the window, and
// one word follows per cycle while the receiver is ready. A stalled receiver holds the
// word and the block takes no input until the run is delivered.
// Reset clears all hits and the window count; the block comes out of reset ready.
module packer_signature_scanner_top #(
    parameter int MAX_VERSION_CHARS  = pss_pkg::MAX_VERSION_CHARS,
    parameter int MARKER_SEARCH_SPAN = pss_pkg::MARKER_SEARCH_SPAN
) (
    input  logic       clk,
    input  logic       rst_n,
    pss_in_if.sink     items,
    pss_out_if.source  results
);

    pss_pkg::pss_cmd_t  cmd;
    pss_pkg::pss_stat_t st;

    pss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (items.valid),
        .action    (items.action),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .st        (st),
        .cmd       (cmd)
    );

    pss_datapath #(
        .MAX_VERSION_CHARS  (MAX_VERSION_CHARS),
        .MARKER_SEARCH_SPAN (MARKER_SEARCH_SPAN)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .st               (st),
        .action           (items.action),
        .data_byte        (items.data_byte),
        .container_is_pe  (items.container_is_pe),
        .canonical_layout (items.canonical_layout),
        .packed_layout    (items.packed_layout),
        .assessment       (results.assessment),
        .header_found     (results.header_found),
        .header_version   (results.header_version),
        .release_found    (results.release_found),
        .release_char     (results.release_char),
        .last_result      (results.last_result)
    );

    // Input and result channels are never open at the same time.
    a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(items.ready && results.valid))
        else $error("input taken while a result word is pending");

    // The last word of a run returns the block to accepting input.
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.ready && results.last_result) |=> items.ready)
        else $error("block not ready after the final result word");

    // A reported header always carries a nonzero version.
    a_hdr_ver: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && results.header_found) |-> (results.header_version != 6'd0))
        else $error("header reported with a zero version");

    // A result word is shown only after the input side has been closed.
    a_emit_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(results.valid) |-> !$past(items.valid && items.ready))
        else $error("result word shown right after an accepted input word");

endmodule

// ===== test/packer_signature_scanner_top_tb.sv =====
// Testbench for the packer signature scanner: directed table, random analyses, scoreboard.
module packer_signature_scanner_top_tb;

    localparam int WIN_LEN     = 4 + pss_pkg::MAX_VERSION_CHARS + pss_pkg::MARKER_SEARCH_SPAN;
    localparam int TXT_W       = 8 * pss_pkg::BANNER_LEN;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int RANDOM_GOAL = 240;
    localparam int DIR_ROWS    = 24;

    typedef logic [TXT_W-1:0] text_t;

    typedef struct {
        pss_pkg::action_t act;
        logic [7:0]       data;
        logic             pe;
        logic             canon;
        logic             packed_lay;
        logic             typed;
        logic [1:0]       t_assess;
        logic             t_hdr;
        logic [5:0]       t_ver;
    } word_t;

    typedef struct {
        logic [1:0] assess;
        logic       hdr;
        logic [5:0] ver;
        logic       rel;
        logic [7:0] ch;
        logic       last;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pss_in_if  items ();
    pss_out_if results ();

    packer_signature_scanner_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source)
    );

    always #2 clk = ~clk;

    // Directed table: act, data, pe, canon, packed, typed, assessment, header, version.
    word_t dir_table[DIR_ROWS] = '{
        '{pss_pkg::ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 2'd2, 1'b0, 6'd0},
        '{pss_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b0, 1'b1, 1'b1, 2'd2, 1'b0, 6'd0},
        '{pss_pkg::ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1, 2'd2, 1'b0, 6'd0},
        '{pss_pkg::ACT_IGNORE, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h50, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h58, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h21, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h3F, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_PREFIX, 8'h0A, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_FINISH, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 2'd1, 1'b1, 6'd63},
        '{pss_pkg::ACT_SUFFIX, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h55, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h50, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h58, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h21, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h02, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_SUFFIX, 8'h01, 1'b0, 1'b0, 1'b0, 1'b0, 2'd0, 1'b0, 6'd0},
        '{pss_pkg::ACT_FINISH, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 2'd0, 1'b0, 6'd0}
    };

    word_t    stim_q[$];
    word_t    offered_q[$];
    verdict_t verdict_q[$];
    int       total_words;
    int       taken_words = 0;
    int       verdicts_seen = 0;
    int       finishes = 0;
    int       errors = 0;
    int       idle_count = 0;
    int       hold_count = 0;
    logic     held = 1'b0;

    // Scanner state mirrored by the predictor.
    logic [7:0] sig_window[WIN_LEN];
    int         win_fill;
    int         region;
    logic       hdr_hit;
    logic [5:0] hdr_ver;
    logic       banner_hit;
    logic       rel_hit;
    logic [7:0] rel_text[pss_pkg::MAX_VERSION_CHARS];
    int         rel_len;

    function automatic void clear_scanner();
        win_fill = 0;
        region = 0;
        hdr_hit = 1'b0;
        hdr_ver = '0;
        banner_hit = 1'b0;
        rel_hit = 1'b0;
        rel_len = 0;
    endfunction

    function automatic void queue_stim(word_t w);
        stim_q = {stim_q, w};
    endfunction

    function automatic void queue_verdict(verdict_t v);
        verdict_q = {verdict_q, v};
    endfunction

    // String constants hold their first character in the top byte.
    function automatic logic text_at(int p, int len, text_t str, int n);
        if (p > len || n > len - p)
            return 1'b0;
        for (int k = 0; k < n; k++)
            if (sig_window[p + k] != str[8*(n-1-k) +: 8])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= pss_pkg::CHAR_ZERO && c <= pss_pkg::CHAR_NINE;
    endfunction

    function automatic void look_header(int len);
        if (hdr_hit || len < pss_pkg::HDR_LEN ||
            !text_at(0, len, text_t'(pss_pkg::HDR_MAGIC), pss_pkg::MAGIC_LEN))
            return;
        if (sig_window[4] > 0 && sig_window[4] < pss_pkg::VER_LIMIT && sig_window[5] != 0 &&
            sig_window[6] != 0 && sig_window[7] >= 1 && sig_window[7] <= pss_pkg::LEVEL_MAX)
        begin
            hdr_hit = 1'b1;
            hdr_ver = sig_window[4][5:0];
        end
    endfunction

    function automatic void look_release(int len);
        int cur;
        int parts;
        int start;
        int stop;
        cur = 4;
        parts = 0;
        if (rel_hit || len <= 4 ||
            !text_at(0, len, text_t'(pss_pkg::REL_LEAD), pss_pkg::MAGIC_LEN))
            return;
        while (parts < 3)
        begin
            start = cur;
            while (cur < len && is_digit(sig_window[cur]))
            begin
                cur++;
                if (cur - 4 > pss_pkg::MAX_VERSION_CHARS)
                    return;
            end
            if (cur == start)
                break;
            parts++;
            if (parts == 3 || cur >= len || sig_window[cur] != pss_pkg::CHAR_DOT)
                break;
            cur++;
            if (cur - 4 > pss_pkg::MAX_VERSION_CHARS)
                return;
        end
        if (parts < 2)
            return;
        stop = cur + pss_pkg::MARKER_SEARCH_SPAN;
        if (stop > len)
            stop = len;
        for (int m = cur; m + pss_pkg::MARK_LEN <= stop; m++)
        begin
            if (text_at(m, len, text_t'(pss_pkg::COPY_MARK), pss_pkg::MARK_LEN))
            begin
                rel_hit = 1'b1;
                rel_len = cur - 4;
                for (int k = 0; k < rel_len; k++)
                    rel_text[k] = sig_window[4 + k];
                return;
            end
        end
    endfunction

    function automatic void scan_head();
        look_header(win_fill);
        look_release(win_fill);
        if (!banner_hit && text_at(0, win_fill, pss_pkg::BANNER_TXT, pss_pkg::BANNER_LEN))
            banner_hit = 1'b1;
        for (int k = 0; k < WIN_LEN - 1; k++)
            sig_window[k] = sig_window[k + 1];
        win_fill--;
    endfunction

    function automatic void drain_window();
        while (win_fill > 0)
            scan_head();
    endfunction

    // Advances the mirrored state by one accepted word and queues the verdict run it causes.
    function automatic void predict_word(word_t w);
        logic det;
        logic std_ok;
        logic [1:0] assess;
        int n;
        verdict_t v;
        if (w.act == pss_pkg::ACT_IGNORE)
            return;
        if (w.act != pss_pkg::ACT_FINISH)
        begin
            if (region != int'(w.act) + 1)
            begin
                drain_window();
                region = int'(w.act) + 1;
            end
            sig_window[win_fill] = w.data;
            win_fill++;
            if (win_fill >= WIN_LEN)
                scan_head();
            return;
        end
        drain_window();
        if (w.pe)
        begin
            det = w.canon || w.packed_lay || hdr_hit;
            std_ok = w.canon && hdr_hit;
        end
        else
        begin
            det = w.packed_lay || hdr_hit || banner_hit || rel_hit;
            std_ok = w.packed_lay && (banner_hit || rel_hit || hdr_hit);
        end
        assess = !det ? pss_pkg::ASSESS_NONE :
                 (std_ok ? pss_pkg::ASSESS_STANDARD : pss_pkg::ASSESS_MODIFIED);
        n = (det && rel_hit && rel_len > 0) ? rel_len : 1;
        if (w.typed)
        begin
            v = '{w.t_assess, w.t_hdr, w.t_ver, 1'b0, 8'h00, 1'b1};
            queue_verdict(v);
        end
        else
        begin
            for (int k = 0; k < n; k++)
            begin
                v.assess = assess;
                v.hdr = det && hdr_hit;
                v.ver = (det && hdr_hit) ? hdr_ver : 6'd0;
                v.rel = det && rel_hit;
                v.ch = (det && rel_hit && k < rel_len) ? rel_text[k] : 8'h00;
                v.last = (k + 1 == n);
                queue_verdict(v);
            end
        end
        finishes++;
        clear_scanner();
    endfunction

    function automatic void add_word(pss_pkg::action_t act, logic [7:0] data);
        word_t w;
        w.act = act;
        w.data = data;
        w.pe = 1'($urandom_range(1));
        w.canon = 1'($urandom_range(1));
        w.packed_lay = 1'($urandom_range(1));
        w.typed = 1'b0;
        w.t_assess = '0;
        w.t_hdr = 1'b0;
        w.t_ver = '0;
        queue_stim(w);
    endfunction

    function automatic void add_text(pss_pkg::action_t act, text_t str, int n);
        for (int k = 0; k < n; k++)
            add_word(act, str[8*(n-1-k) +: 8]);
    endfunction

    // Random well-formed or slightly broken piece of a region.
    function automatic void add_piece(pss_pkg::action_t act);
        int kind;
        int parts;
        int digits;
        kind = $urandom_range(9);
        if (kind < 2)
        begin
            repeat ($urandom_range(6)) add_word(act, 8'($urandom_range(255)));
        end
        else if (kind < 4)
        begin
            add_text(act, text_t'(pss_pkg::HDR_MAGIC), pss_pkg::MAGIC_LEN);
            add_word(act, 8'(($urandom_range(4) == 0) ? $urandom_range(255)
                                                      : $urandom_range(1, 63)));
            add_word(act, ($urandom_range(6) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
            add_word(act, ($urandom_range(6) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
            add_word(act, 8'($urandom_range(12)));
        end
        else if (kind < 5)
        begin
            add_text(act, pss_pkg::BANNER_TXT,
                     pss_pkg::BANNER_LEN - int'($urandom_range(5) == 0));
        end
        else
        begin
            add_text(act, text_t'(pss_pkg::REL_LEAD), pss_pkg::MAGIC_LEN);
            parts = $urandom_range(1, 4);
            for (int p = 0; p < parts; p++)
            begin
                digits = ($urandom_range(7) == 0) ? $urandom_range(6, 10) : $urandom_range(1, 3);
                repeat (digits) add_word(act, 8'(pss_pkg::CHAR_ZERO + $urandom_range(9)));
                if (p + 1 < parts || $urandom_range(3) == 0)
                    add_word(act, pss_pkg::CHAR_DOT);
            end
            repeat (($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(2))
                add_word(act, 8'(8'h61 + $urandom_range(20)));
            if ($urandom_range(5) != 0)
                add_text(act, text_t'(pss_pkg::COPY_MARK), pss_pkg::MARK_LEN);
        end
    endfunction

    function automatic void build_stimulus();
        int start;
        pss_pkg::action_t act;
        foreach (dir_table[i])
            queue_stim(dir_table[i]);
        // Random analyses: regions in any order, sometimes repeated.
        start = stim_q.size();
        while (stim_q.size() - start < RANDOM_GOAL)
        begin
            repeat ($urandom_range(1, 3))
            begin
                act = ($urandom_range(3) == 0) ? pss_pkg::ACT_SUFFIX : pss_pkg::ACT_PREFIX;
                if ($urandom_range(2) != 0)
                    act = pss_pkg::action_t'(stim_q.size() % 2);
                repeat ($urandom_range(1, 3)) add_piece(act);
                if ($urandom_range(9) == 0)
                    add_word(pss_pkg::ACT_IGNORE, 8'($urandom_range(255)));
            end
            add_word(pss_pkg::ACT_FINISH, 8'($urandom_range(255)));
        end
    endfunction

    function automatic int sender_idle_pct(int n);
        if (n < total_words / 3) return 7;
        if (n < 2 * total_words / 3) return 82;
        return 0;
    endfunction

    function automatic int receiver_idle_pct(int n);
        if (n < total_words / 3) return 82;
        if (n < 2 * total_words / 3) return 7;
        return 0;
    endfunction

    // Sender.
    always @(posedge clk or negedge rst_n)
    begin
        word_t w;
        if (!rst_n)
        begin
            items.valid <= 1'b0;
            items.action <= pss_pkg::ACT_PREFIX;
            items.data_byte <= '0;
            items.container_is_pe <= 1'b0;
            items.canonical_layout <= 1'b0;
            items.packed_layout <= 1'b0;
        end
        else if (!items.valid || items.ready)
        begin
            if (stim_q.size() > 0 && $urandom_range(99) >= sender_idle_pct(taken_words))
            begin
                w = stim_q.pop_front();
                items.action <= w.act;
                items.data_byte <= w.data;
                items.container_is_pe <= w.pe;
                items.canonical_layout <= w.canon;
                items.packed_layout <= w.packed_lay;
                items.valid <= 1'b1;
            end
            else
            begin
                items.valid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off at the start of the last third.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results.ready <= 1'b0;
        end
        else if (hold_count > 0)
        begin
            results.ready <= 1'b0;
            hold_count <= hold_count - 1;
        end
        else if (!held && taken_words >= 2 * total_words / 3)
        begin
            held <= 1'b1;
            hold_count <= HOLD_CYCLES;
            results.ready <= 1'b0;
        end
        else
        begin
            results.ready <= $urandom_range(99) >= receiver_idle_pct(taken_words);
        end
    end

    // Input monitor drives the predictor from what the block accepted.
    always @(posedge clk)
    begin
        word_t w;
        if (rst_n && items.valid && items.ready)
        begin
            w = offered_q.pop_front();
            predict_word(w);
            taken_words <= taken_words + 1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        verdict_t e;
        if (rst_n && results.valid && results.ready)
        begin
            verdicts_seen <= verdicts_seen + 1;
            if (verdict_q.size() == 0)
            begin
                $display("%0t: unexpected result word, assessment %0d char %h", $time,
                         results.assessment, results.release_char);
                errors++;
            end
            else
            begin
                e = verdict_q.pop_front();
                if (results.assessment !== e.assess)
                begin
                    $display("%0t: assessment expected %0d actual %0d", $time, e.assess,
                             results.assessment);
                    errors++;
                end
                if (results.header_found !== e.hdr)
                begin
                    $display("%0t: header_found expected %0d actual %0d", $time, e.hdr,
                             results.header_found);
                    errors++;
                end
                if (results.header_version !== e.ver)
                begin
                    $display("%0t: header_version expected %0d actual %0d", $time, e.ver,
                             results.header_version);
                    errors++;
                end
                if (results.release_found !== e.rel)
                begin
                    $display("%0t: release_found expected %0d actual %0d", $time, e.rel,
                             results.release_found);
                    errors++;
                end
                if (results.release_char !== e.ch)
                begin
                    $display("%0t: release_char expected %h actual %h", $time, e.ch,
                             results.release_char);
                    errors++;
                end
                if (results.last_result !== e.last)
                begin
                    $display("%0t: last_result expected %0d actual %0d", $time, e.last,
                             results.last_result);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if ((items.valid && items.ready) || (results.valid && results.ready))
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        clear_scanner();
        build_stimulus();
        offered_q = stim_q;
        total_words = stim_q.size();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        while (taken_words < total_words || verdict_q.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d input words in %0d analyses, %0d result words checked,",
                 total_words, finishes, verdicts_seen);
        $display("with idle mixes on both sides and one long result back-pressure stretch.");
        if (errors == 0 && verdict_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
